// ===== sv/sbfh_pkg.sv =====
// shared types, codes and constants of the sparse block fill histogram
`timescale 1ns / 1ps

package sbfh_pkg;

    localparam int ROW_W    = 20;
    localparam int ROWS_W   = 21;
    localparam int DIM_W    = 4;
    localparam int NCOLS_W  = 13;
    localparam int CFG_W    = 21;
    localparam int COUNT_W  = 32;
    localparam int RECIP_SH = 24;
    localparam int RECIP_W  = 25;
    localparam int PROD_W   = ROWS_W + RECIP_SH;

    typedef enum logic [1:0] {
        REQ_NONZERO   = 2'd0,
        REQ_END_ROW   = 2'd1,
        REQ_READ_BIN  = 2'd2,
        REQ_CLEAR_ALL = 2'd3
    } sbfh_req_t;

    typedef enum logic [1:0] {
        CFG_BLOCK_ROWS = 2'd0,
        CFG_BLOCK_COLS = 2'd1,
        CFG_NUM_ROWS   = 2'd2,
        CFG_NUM_COLS   = 2'd3
    } sbfh_cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NZ_MUL,
        ST_NZ_RD,
        ST_NZ_WR,
        ST_EOR_MUL,
        ST_EOR_CHK,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_SWP_RD,
        ST_SWP_HR,
        ST_SWP_WR,
        ST_DONE
    } sbfh_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] column;
        logic [6:0]  bin_index;
    } sbfh_in_t;

    typedef struct packed {
        logic [31:0] bin_count;
        logic        flushed;
        logic        error;
    } sbfh_out_t;

    typedef struct packed {
        logic      s_valid;
        sbfh_req_t req;
        logic      col_err;
        logic      bin_err;
        logic      last_row;
        logic      mod_zero;
        logic      counted;
        logic      sweep_cont;
        logic      clear_cont;
        logic      pend;
        logic      out_free;
    } sbfh_status_t;

    typedef struct packed {
        sbfh_state_t state;
        logic        s_ready;
        logic        accept;
        logic        idx_clr;
        logic        idx_step;
        logic        hw_zero;
        logic        res_load;
    } sbfh_ctrl_t;

    // scaled reciprocals, exact floor division of values below 2^21 by 1..8
    function automatic logic [RECIP_W-1:0] recip(input logic [DIM_W-1:0] d);
        logic [RECIP_W-1:0] r;
        begin
            case (d)
                4'd1: begin
                    r = 25'd16777216;
                end
                4'd2: begin
                    r = 25'd8388608;
                end
                4'd3: begin
                    r = 25'd5592406;
                end
                4'd4: begin
                    r = 25'd4194304;
                end
                4'd5: begin
                    r = 25'd3355444;
                end
                4'd6: begin
                    r = 25'd2796203;
                end
                4'd7: begin
                    r = 25'd2396746;
                end
                4'd8: begin
                    r = 25'd2097152;
                end
                default: begin
                    r = 25'd16777216;
                end
            endcase
            recip = r;
        end
    endfunction

endpackage

// ===== sv/sbfh_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module sbfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sbfh_div.sv =====
// shared reciprocal divider by 1..8, quotient registered in the cycle after enable
`timescale 1ns / 1ps

module sbfh_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [sbfh_pkg::ROWS_W-1:0]   dividend,
    input  logic [sbfh_pkg::DIM_W-1:0]    divisor,
    output logic [sbfh_pkg::ROWS_W-1:0]   quot
);

    logic [sbfh_pkg::PROD_W-1:0] prod;
    logic [sbfh_pkg::PROD_W-1:0] prod_reg;

    assign prod = sbfh_pkg::PROD_W'(dividend)
                * sbfh_pkg::PROD_W'(sbfh_pkg::recip(divisor));

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod;
        end
    end

    assign quot = prod_reg[sbfh_pkg::PROD_W-1:sbfh_pkg::RECIP_SH];

endmodule

// ===== sv/sbfh_ctrl.sv =====
// sequencer for requests, counter sweeps and clearing passes
`timescale 1ns / 1ps

module sbfh_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sbfh_pkg::sbfh_status_t st,
    output sbfh_pkg::sbfh_ctrl_t   ctl
);

    sbfh_pkg::sbfh_state_t state_reg;
    sbfh_pkg::sbfh_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbfh_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbfh_pkg::ST_CLEAR: begin
                if (!st.clear_cont) begin
                    state_next = st.pend ? sbfh_pkg::ST_DONE : sbfh_pkg::ST_IDLE;
                end
            end
            sbfh_pkg::ST_IDLE: begin
                if (st.s_valid) begin
                    case (st.req)
                        sbfh_pkg::REQ_NONZERO: begin
                            state_next = st.col_err ? sbfh_pkg::ST_DONE
                                                    : sbfh_pkg::ST_NZ_MUL;
                        end
                        sbfh_pkg::REQ_END_ROW: begin
                            state_next = st.last_row ? sbfh_pkg::ST_SWP_RD
                                                     : sbfh_pkg::ST_EOR_MUL;
                        end
                        sbfh_pkg::REQ_READ_BIN: begin
                            state_next = st.bin_err ? sbfh_pkg::ST_DONE
                                                    : sbfh_pkg::ST_RD_ADDR;
                        end
                        default: begin
                            state_next = sbfh_pkg::ST_CLEAR;
                        end
                    endcase
                end
            end
            sbfh_pkg::ST_NZ_MUL: begin
                state_next = sbfh_pkg::ST_NZ_RD;
            end
            sbfh_pkg::ST_NZ_RD: begin
                state_next = sbfh_pkg::ST_NZ_WR;
            end
            sbfh_pkg::ST_NZ_WR: begin
                state_next = sbfh_pkg::ST_DONE;
            end
            sbfh_pkg::ST_EOR_MUL: begin
                state_next = sbfh_pkg::ST_EOR_CHK;
            end
            sbfh_pkg::ST_EOR_CHK: begin
                state_next = st.mod_zero ? sbfh_pkg::ST_SWP_RD : sbfh_pkg::ST_DONE;
            end
            sbfh_pkg::ST_RD_ADDR: begin
                state_next = sbfh_pkg::ST_RD_DATA;
            end
            sbfh_pkg::ST_RD_DATA: begin
                state_next = sbfh_pkg::ST_DONE;
            end
            sbfh_pkg::ST_SWP_RD: begin
                if (st.counted) begin
                    state_next = sbfh_pkg::ST_SWP_HR;
                end else if (!st.sweep_cont) begin
                    state_next = sbfh_pkg::ST_DONE;
                end
            end
            sbfh_pkg::ST_SWP_HR: begin
                state_next = sbfh_pkg::ST_SWP_WR;
            end
            sbfh_pkg::ST_SWP_WR: begin
                state_next = st.sweep_cont ? sbfh_pkg::ST_SWP_RD : sbfh_pkg::ST_DONE;
            end
            sbfh_pkg::ST_DONE: begin
                if (st.out_free) begin
                    state_next = sbfh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbfh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl          = '0;
        ctl.state    = state_reg;
        ctl.s_ready  = (state_reg == sbfh_pkg::ST_IDLE);
        ctl.accept   = (state_reg == sbfh_pkg::ST_IDLE) && st.s_valid;
        ctl.idx_clr  = (state_reg == sbfh_pkg::ST_IDLE)
                    || (state_reg == sbfh_pkg::ST_EOR_CHK);
        ctl.idx_step = (state_reg == sbfh_pkg::ST_CLEAR)
                    || ((state_reg == sbfh_pkg::ST_SWP_RD) && !st.counted)
                    || (state_reg == sbfh_pkg::ST_SWP_WR);
        ctl.hw_zero  = ((state_reg == sbfh_pkg::ST_CLEAR) && !st.clear_cont)
                    || ((state_reg == sbfh_pkg::ST_SWP_RD) && !st.counted
                        && !st.sweep_cont)
                    || ((state_reg == sbfh_pkg::ST_SWP_WR) && !st.sweep_cont);
        ctl.res_load = (state_reg == sbfh_pkg::ST_DONE) && st.out_free;
    end

endmodule

// ===== sv/sparse_block_fill_histogram_core.sv =====
// top level of the sparse block fill histogram
`timescale 1ns / 1ps

// Takes nonzero column indices and end-of-row markers of a row-major sparse
// matrix, counts nonzeros per column block in a memory of MAX_COLS counters and,
// when a row block closes or the last row ends, sweeps the counters into a
// histogram memory of MAX_BLOCK_DIM^2+1 saturating bins that can be read back.
// One request is handled at a time; every request gives exactly one result,
// held in an output register so the next request can be taken while it waits.
// A nonzero entry passes the divider, a counter read and a counter write; an end
// of row without flush passes the divider and a row position check; a bin read
// reads the histogram; a bad column or bad bin goes straight to the result. A
// flush takes each column block counted through a counter read, a histogram read
// and a histogram write, through memories with one read and one write port, and
// clears each further block up to the highest block written since the last
// sweep. An end of row that closes the matrix skips the divider. Clear all
// clears the counters up to the highest block written since the last sweep and
// all MAX_BLOCK_DIM^2+1 bins; after reset all MAX_COLS counters and all bins are
// cleared before the first request is taken. Configuration writes are always
// taken, but they belong between requests, with no result outstanding.
module sparse_block_fill_histogram_core #(
    parameter int MAX_COLS      = 4096,
    parameter int MAX_BLOCK_DIM = 8,
    parameter int HIST_WIDTH    = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sbfh_pkg::sbfh_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sbfh_pkg::sbfh_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [sbfh_pkg::CFG_W-1:0]        cfg_data
);

    localparam int HIST_BINS = MAX_BLOCK_DIM * MAX_BLOCK_DIM + 1;
    localparam int HAW       = $clog2(HIST_BINS);
    localparam int CAW       = $clog2(MAX_COLS);
    localparam int SW        = $clog2(MAX_COLS + 1);
    localparam int ECW       = $clog2(MAX_COLS + 9);
    localparam int XW        = (ECW > sbfh_pkg::NCOLS_W) ? ECW : sbfh_pkg::NCOLS_W;
    localparam int IW        = $clog2(MAX_COLS + HIST_BINS + 1);
    localparam int HXW       = (HIST_WIDTH > sbfh_pkg::COUNT_W) ? HIST_WIDTH
                                                                : sbfh_pkg::COUNT_W;

    sbfh_pkg::sbfh_status_t st;
    sbfh_pkg::sbfh_ctrl_t   ctl;

    logic [sbfh_pkg::DIM_W-1:0]   block_rows_reg;
    logic [sbfh_pkg::DIM_W-1:0]   block_cols_reg;
    logic [sbfh_pkg::ROWS_W-1:0]  num_rows_reg;
    logic [sbfh_pkg::NCOLS_W-1:0] num_cols_reg;

    sbfh_pkg::sbfh_in_t           in_reg;
    sbfh_pkg::sbfh_out_t          m_data_reg;
    logic                         m_valid_reg;
    logic                         pend_reg;
    logic [sbfh_pkg::ROW_W-1:0]   rc_reg;
    logic [sbfh_pkg::ROWS_W-1:0]  row_next_reg;
    logic [SW-1:0]                hw_reg;
    logic [IW-1:0]                i_reg;
    logic [ECW-1:0]               cb_reg;
    logic [HAW-1:0]               bin_reg;
    logic [sbfh_pkg::COUNT_W-1:0] res_count_reg;
    logic                         res_flushed_reg;
    logic                         res_error_reg;

    logic [sbfh_pkg::DIM_W-1:0]   br_eff;
    logic [sbfh_pkg::DIM_W-1:0]   bc_eff;
    logic [7:0]                   cap_prod;
    logic [HAW-1:0]               cap;
    logic [ECW-1:0]               eff_cols;
    logic [sbfh_pkg::ROWS_W-1:0]  rows_eff;
    logic [sbfh_pkg::ROWS_W-1:0]  row_next;
    logic [sbfh_pkg::RECIP_W-1:0] mod_prod;
    logic [IW-1:0]                i_inc;
    logic [ECW-1:0]               cb_inc;
    logic [IW-1:0]                clear_end;
    logic [SW-1:0]                blk_inc;

    logic                         div_en;
    logic [sbfh_pkg::ROWS_W-1:0]  div_dividend;
    logic [sbfh_pkg::DIM_W-1:0]   div_divisor;
    logic [sbfh_pkg::ROWS_W-1:0]  div_quot;
    logic [CAW-1:0]               blk;

    logic                         cnt_we;
    logic [CAW-1:0]               cnt_waddr;
    logic [HAW-1:0]               cnt_wdata;
    logic [CAW-1:0]               cnt_raddr;
    logic [HAW-1:0]               cnt_rdata;

    logic                         hist_we;
    logic [HAW-1:0]               hist_waddr;
    logic [HIST_WIDTH-1:0]        hist_wdata;
    logic [HAW-1:0]               hist_raddr;
    logic [HIST_WIDTH-1:0]        hist_rdata;
    logic [HXW-1:0]               hist_ext;
    logic [sbfh_pkg::COUNT_W-1:0] count_sat;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_rows_reg <= 4'd1;
            block_cols_reg <= 4'd1;
            num_rows_reg   <= 21'd1;
            num_cols_reg   <= 13'd4096;
        end else if (cfg_valid) begin
            case (sbfh_pkg::sbfh_cfg_t'(cfg_index))
                sbfh_pkg::CFG_BLOCK_ROWS: begin
                    block_rows_reg <= cfg_data[sbfh_pkg::DIM_W-1:0];
                end
                sbfh_pkg::CFG_BLOCK_COLS: begin
                    block_cols_reg <= cfg_data[sbfh_pkg::DIM_W-1:0];
                end
                sbfh_pkg::CFG_NUM_ROWS: begin
                    num_rows_reg <= cfg_data;
                end
                sbfh_pkg::CFG_NUM_COLS: begin
                    num_cols_reg <= cfg_data[sbfh_pkg::NCOLS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        br_eff = block_rows_reg;
        if (block_rows_reg == 4'd0) begin
            br_eff = 4'd1;
        end else if (block_rows_reg > 4'(MAX_BLOCK_DIM)) begin
            br_eff = 4'(MAX_BLOCK_DIM);
        end
        bc_eff = block_cols_reg;
        if (block_cols_reg == 4'd0) begin
            bc_eff = 4'd1;
        end else if (block_cols_reg > 4'(MAX_BLOCK_DIM)) begin
            bc_eff = 4'(MAX_BLOCK_DIM);
        end
        eff_cols = ECW'(num_cols_reg);
        if (num_cols_reg == 13'd0) begin
            eff_cols = ECW'(1);
        end else if (XW'(num_cols_reg) > XW'(MAX_COLS)) begin
            eff_cols = ECW'(MAX_COLS);
        end
    end

    assign cap_prod = 8'(br_eff) * 8'(bc_eff);
    assign cap      = cap_prod[HAW-1:0];
    assign rows_eff = (num_rows_reg == 21'd0) ? 21'd1 : num_rows_reg;
    assign row_next = sbfh_pkg::ROWS_W'(rc_reg) + 21'd1;

    // shared divider: column block of a nonzero, row position within a block
    assign div_en       = (ctl.state == sbfh_pkg::ST_NZ_MUL)
                       || (ctl.state == sbfh_pkg::ST_EOR_MUL);
    assign div_dividend = (ctl.state == sbfh_pkg::ST_NZ_MUL)
                        ? sbfh_pkg::ROWS_W'(in_reg.column) : row_next_reg;
    assign div_divisor  = (ctl.state == sbfh_pkg::ST_NZ_MUL) ? bc_eff : br_eff;

    sbfh_div u_div (
        .aclk     (aclk),
        .en       (div_en),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot)
    );

    assign blk      = div_quot[CAW-1:0];
    assign blk_inc  = SW'(blk) + SW'(1);
    assign mod_prod = sbfh_pkg::RECIP_W'(div_quot) * sbfh_pkg::RECIP_W'(br_eff);

    assign i_inc     = i_reg + IW'(1);
    assign cb_inc    = cb_reg + ECW'(bc_eff);
    assign clear_end = (IW'(hw_reg) > IW'(HIST_BINS)) ? IW'(hw_reg) : IW'(HIST_BINS);

    // status toward the sequencer
    always_comb begin
        st            = '0;
        st.s_valid    = s_valid;
        st.req        = sbfh_pkg::sbfh_req_t'(s_data.req_type);
        st.col_err    = XW'(s_data.column) >= XW'(eff_cols);
        st.bin_err    = 8'(s_data.bin_index) > 8'(cap);
        st.last_row   = row_next >= rows_eff;
        st.mod_zero   = mod_prod == sbfh_pkg::RECIP_W'(row_next_reg);
        st.counted    = cb_reg < eff_cols;
        st.sweep_cont = (i_inc < IW'(hw_reg)) || (cb_inc < eff_cols);
        st.clear_cont = i_inc < clear_end;
        st.pend       = pend_reg;
        st.out_free   = !m_valid_reg || m_ready;
    end

    sbfh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .ctl     (ctl)
    );

    assign s_ready = ctl.s_ready;

    // block counter memory
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = i_reg[CAW-1:0];
        cnt_wdata = '0;
        cnt_raddr = i_reg[CAW-1:0];
        case (ctl.state)
            sbfh_pkg::ST_CLEAR: begin
                cnt_we = i_reg < IW'(hw_reg);
            end
            sbfh_pkg::ST_NZ_RD: begin
                cnt_raddr = blk;
            end
            sbfh_pkg::ST_NZ_WR: begin
                cnt_waddr = blk;
                cnt_wdata = cnt_rdata + HAW'(1);
                cnt_we    = cnt_rdata < cap;
            end
            sbfh_pkg::ST_SWP_RD: begin
                cnt_we = !st.counted;
            end
            sbfh_pkg::ST_SWP_HR: begin
                cnt_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    sbfh_ram #(
        .WIDTH (HAW),
        .DEPTH (MAX_COLS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // histogram memory
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = bin_reg;
        hist_wdata = hist_rdata + HIST_WIDTH'(1);
        hist_raddr = cnt_rdata;
        case (ctl.state)
            sbfh_pkg::ST_CLEAR: begin
                hist_we    = i_reg < IW'(HIST_BINS);
                hist_waddr = i_reg[HAW-1:0];
                hist_wdata = '0;
            end
            sbfh_pkg::ST_RD_ADDR: begin
                hist_raddr = in_reg.bin_index[HAW-1:0];
            end
            sbfh_pkg::ST_SWP_WR: begin
                hist_we = hist_rdata != '1;
            end
            default: begin
            end
        endcase
    end

    sbfh_ram #(
        .WIDTH (HIST_WIDTH),
        .DEPTH (HIST_BINS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign hist_ext  = HXW'(hist_rdata);
    assign count_sat = (hist_ext > HXW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                        : hist_ext[sbfh_pkg::COUNT_W-1:0];

    // datapath registers
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            in_reg       <= s_data;
            row_next_reg <= row_next;
        end
        if (ctl.state == sbfh_pkg::ST_SWP_HR) begin
            bin_reg <= cnt_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            rc_reg   <= '0;
            hw_reg   <= SW'(MAX_COLS);
            i_reg    <= '0;
            cb_reg   <= '0;
        end else begin
            if (ctl.accept) begin
                pend_reg <= 1'b1;
            end else if (ctl.res_load) begin
                pend_reg <= 1'b0;
            end
            if (ctl.accept && (st.req == sbfh_pkg::REQ_END_ROW)) begin
                rc_reg <= st.last_row ? '0 : row_next[sbfh_pkg::ROW_W-1:0];
            end else if (ctl.accept && (st.req == sbfh_pkg::REQ_CLEAR_ALL)) begin
                rc_reg <= '0;
            end
            if (ctl.hw_zero) begin
                hw_reg <= '0;
            end else if ((ctl.state == sbfh_pkg::ST_NZ_RD) && (blk_inc > hw_reg)) begin
                hw_reg <= blk_inc;
            end
            if (ctl.idx_clr) begin
                i_reg  <= '0;
                cb_reg <= '0;
            end else if (ctl.idx_step) begin
                i_reg  <= i_inc;
                cb_reg <= cb_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            res_count_reg   <= '0;
            res_flushed_reg <= (st.req == sbfh_pkg::REQ_END_ROW) && st.last_row;
            res_error_reg   <= ((st.req == sbfh_pkg::REQ_NONZERO) && st.col_err)
                            || ((st.req == sbfh_pkg::REQ_READ_BIN) && st.bin_err);
        end else begin
            if (ctl.state == sbfh_pkg::ST_RD_DATA) begin
                res_count_reg <= count_sat;
            end
            if ((ctl.state == sbfh_pkg::ST_EOR_CHK) && st.mod_zero) begin
                res_flushed_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.res_load) begin
            m_data_reg.bin_count <= res_count_reg;
            m_data_reg.flushed   <= res_flushed_reg;
            m_data_reg.error     <= res_error_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/sbfh_checker.sv =====
// port checker for the sparse block fill histogram and its bind
`timescale 1ns / 1ps

module sbfh_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sbfh_pkg::sbfh_out_t m_data
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one request at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after an input transfer");

    // a flush and an error never come together
    a_flush_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.flushed && m_data.error))
        else $error("flushed and error both set");

    // only a good bin read carries a count
    a_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.flushed || m_data.error) |-> m_data.bin_count == 32'd0)
        else $error("count on a flush or error result");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind sparse_block_fill_histogram_core sbfh_checker u_sbfh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/sparse_block_fill_histogram_core_test.sv =====
// self-checking testbench for the sparse block fill histogram core
`timescale 1ns / 1ps

module sparse_block_fill_histogram_core_test;
    import sbfh_pkg::*;

    localparam int MAX_COLS      = 4096;
    localparam int MAX_BLOCK_DIM = 8;
    localparam int HIST_WIDTH    = 32;
    localparam int HIST_BINS     = MAX_BLOCK_DIM * MAX_BLOCK_DIM + 1;
    localparam longint unsigned HIST_TOP = 64'hFFFF_FFFF;
    localparam int RANDOM_REQUESTS = 1600;
    localparam int STALL_LIMIT     = 80000;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    sbfh_in_t           s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    sbfh_out_t          m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    // predicted registers and state of the block
    bit [DIM_W-1:0]     br_reg   = 4'd1;
    bit [DIM_W-1:0]     bc_reg   = 4'd1;
    bit [ROWS_W-1:0]    rows_reg = 21'd1;
    bit [NCOLS_W-1:0]   cols_reg = 13'd4096;
    int unsigned        blk_fill [MAX_COLS];
    longint unsigned    fill_hist [HIST_BINS];
    bit [ROW_W-1:0]     row_pos  = '0;

    sbfh_out_t          pending_outputs [$];
    bit                 no_idle         = 1'b0;
    int unsigned        requests_sent   = 0;
    int unsigned        outputs_checked = 0;
    int unsigned        flushes_seen    = 0;
    int unsigned        register_loads  = 0;
    int unsigned        mismatches      = 0;
    int unsigned        quiet_cycles    = 0;

    sparse_block_fill_histogram_core #(
        .MAX_COLS      (MAX_COLS),
        .MAX_BLOCK_DIM (MAX_BLOCK_DIM),
        .HIST_WIDTH    (HIST_WIDTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned dim_eff(input bit [DIM_W-1:0] v);
        dim_eff = (v == 0) ? 1 : ((v > MAX_BLOCK_DIM) ? MAX_BLOCK_DIM : int'(v));
    endfunction

    function automatic int unsigned cols_eff();
        cols_eff = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg));
    endfunction

    function automatic sbfh_out_t step_histogram(input sbfh_in_t item);
        sbfh_out_t   res;
        int unsigned br;
        int unsigned bc;
        int unsigned cap;
        int unsigned ncols;
        int unsigned nrows;
        int unsigned nblk;
        int unsigned nxt;
        int unsigned i;
        res   = '0;
        br    = dim_eff(br_reg);
        bc    = dim_eff(bc_reg);
        cap   = br * bc;
        ncols = cols_eff();
        case (item.req_type)
            REQ_NONZERO: begin
                if (item.column >= ncols) begin
                    res.error = 1'b1;
                end else if (blk_fill[item.column / bc] < cap) begin
                    blk_fill[item.column / bc]++;
                end
            end
            REQ_END_ROW: begin
                nrows = (rows_reg == 0) ? 1 : int'(rows_reg);
                nxt   = int'(row_pos) + 1;
                if (nxt >= nrows) begin
                    res.flushed = 1'b1;
                    row_pos     = '0;
                end else begin
                    res.flushed = (nxt % br == 0);
                    row_pos     = nxt[ROW_W-1:0];
                end
                if (res.flushed) begin
                    nblk = (ncols + bc - 1) / bc;
                    for (i = 0; i < nblk; i++) begin
                        if (fill_hist[blk_fill[i]] < HIST_TOP) begin
                            fill_hist[blk_fill[i]]++;
                        end
                    end
                    for (i = 0; i < MAX_COLS; i++) begin
                        blk_fill[i] = 0;
                    end
                end
            end
            REQ_READ_BIN: begin
                if (item.bin_index > cap || item.bin_index >= HIST_BINS) begin
                    res.error = 1'b1;
                end else begin
                    res.bin_count = fill_hist[item.bin_index][31:0];
                end
            end
            default: begin
                for (i = 0; i < MAX_COLS; i++) begin
                    blk_fill[i] = 0;
                end
                for (i = 0; i < HIST_BINS; i++) begin
                    fill_hist[i] = 0;
                end
                row_pos = '0;
            end
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        mismatches++;
        if (mismatches <= 20) begin
            $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
        end
    endtask

    // result transfers happen at the edge after the sampling point
    always @(negedge aclk) begin : check_outputs
        sbfh_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                flag_mismatch("unexpected result", m_data.bin_count, 0);
            end else begin
                want = pending_outputs.pop_front();
                outputs_checked++;
                if (m_data.flushed === 1'b1) begin
                    flushes_seen++;
                end
                if (m_data.bin_count !== want.bin_count) begin
                    flag_mismatch("bin_count", m_data.bin_count, want.bin_count);
                end
                if (m_data.flushed !== want.flushed) begin
                    flag_mismatch("flushed", m_data.flushed, want.flushed);
                end
                if (m_data.error !== want.error) begin
                    flag_mismatch("error", m_data.error, want.error);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles > STALL_LIMIT) begin
            $display("no transfer for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && (no_idle || $urandom_range(99) >= 32);
    end

    task automatic send_req(input sbfh_req_t req, input logic [11:0] col,
                            input logic [6:0] bin);
        sbfh_in_t item;
        item.req_type  = req;
        item.column    = col;
        item.bin_index = bin;
        if (!no_idle) begin
            while ($urandom_range(99) < 32) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        pending_outputs.push_back(step_histogram(item));
        requests_sent++;
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input sbfh_cfg_t idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        case (idx)
            CFG_BLOCK_ROWS: br_reg   = val[DIM_W-1:0];
            CFG_BLOCK_COLS: bc_reg   = val[DIM_W-1:0];
            CFG_NUM_ROWS:   rows_reg = val[ROWS_W-1:0];
            default:        cols_reg = val[NCOLS_W-1:0];
        endcase
    endtask

    task automatic load_config(input logic [CFG_W-1:0] rows_blk, input logic [CFG_W-1:0] cols_blk,
                               input logic [CFG_W-1:0] rows_all, input logic [CFG_W-1:0] cols_all);
        drain_outputs();
        write_reg(CFG_BLOCK_ROWS, rows_blk);
        write_reg(CFG_BLOCK_COLS, cols_blk);
        write_reg(CFG_NUM_ROWS, rows_all);
        write_reg(CFG_NUM_COLS, cols_all);
        cfg_valid <= 1'b0;
        register_loads++;
    endtask

    // reset values: every end of row sweeps all 4096 single-column blocks
    task automatic test_reset_registers();
        send_req(REQ_NONZERO, 12'd0, 7'h7F);
        send_req(REQ_NONZERO, 12'd4095, 7'd0);
        send_req(REQ_NONZERO, 12'd0, 7'd0);
        send_req(REQ_END_ROW, 12'hFFF, 7'h7F);
        send_req(REQ_READ_BIN, 12'd0, 7'd0);
        send_req(REQ_READ_BIN, 12'hFFF, 7'd1);
        send_req(REQ_READ_BIN, 12'd0, 7'd2);
    endtask

    // zero and oversized register values clamp
    task automatic test_register_clamps();
        load_config(21'h1FFFF0, 21'd15, 21'd0, 21'd0);
        send_req(REQ_NONZERO, 12'd0, 7'd0);
        send_req(REQ_NONZERO, 12'd1, 7'd0);
        send_req(REQ_END_ROW, 12'd0, 7'd0);
        send_req(REQ_READ_BIN, 12'd0, 7'd8);
        send_req(REQ_READ_BIN, 12'd0, 7'd9);
        send_req(REQ_READ_BIN, 12'd0, 7'h7F);
    endtask

    // repeated columns saturate the block counter at block_rows*block_cols
    task automatic test_counter_saturation();
        int unsigned j;
        load_config(21'd2, 21'd1, 21'd2, 21'd8);
        for (j = 0; j < 3; j++) begin
            send_req(REQ_NONZERO, 12'd5, 7'd0);
        end
        send_req(REQ_NONZERO, 12'd7, 7'd0);
        send_req(REQ_END_ROW, 12'd0, 7'd0);
        send_req(REQ_NONZERO, 12'd7, 7'd0);
        send_req(REQ_END_ROW, 12'd0, 7'd0);
        send_req(REQ_READ_BIN, 12'd0, 7'd2);
        send_req(REQ_READ_BIN, 12'd0, 7'd0);
    endtask

    // row-block flush, last-row wrap, and clear all
    task automatic test_rows_and_clear();
        int unsigned j;
        load_config(21'd3, 21'd2, 21'd4, 21'd10);
        for (j = 0; j < 5; j++) begin
            send_req(REQ_END_ROW, 12'd0, 7'd0);
        end
        send_req(REQ_NONZERO, 12'd9, 7'd0);
        send_req(REQ_CLEAR_ALL, 12'hABC, 7'h55);
        send_req(REQ_READ_BIN, 12'd0, 7'd0);
        send_req(REQ_END_ROW, 12'd0, 7'd0);
    endtask

    task automatic test_random_matrices();
        int unsigned base;
        int unsigned start;
        int unsigned phase;
        int unsigned phase_len;
        int unsigned roll;
        int unsigned sel;
        int unsigned k;
        int unsigned j;
        int unsigned ncols;
        int unsigned nblk;
        int unsigned cap;
        int unsigned hot;
        int unsigned col;
        int unsigned br_raw;
        int unsigned bc_raw;
        int unsigned nr_raw;
        int unsigned nc_raw;
        base  = requests_sent;
        phase = 0;
        while (requests_sent - base < RANDOM_REQUESTS) begin
            sel    = $urandom_range(99);
            br_raw = (sel < 15) ? ($urandom_range(1) ? 0 : $urandom_range(9, 15))
                                : $urandom_range(1, 8);
            sel    = $urandom_range(99);
            bc_raw = (sel < 15) ? ($urandom_range(1) ? 0 : $urandom_range(9, 15))
                                : $urandom_range(1, 8);
            sel    = $urandom_range(99);
            if (sel < 60)      nc_raw = $urandom_range(1, 64);
            else if (sel < 85) nc_raw = $urandom_range(65, 600);
            else if (sel < 90) nc_raw = 0;
            else               nc_raw = $urandom_range(0, 8191);
            sel    = $urandom_range(99);
            if (sel < 75)      nr_raw = $urandom_range(1, 24);
            else if (sel < 85) nr_raw = 0;
            else               nr_raw = $urandom_range(0, 2097151);
            load_config(CFG_W'(($urandom & 32'h1FFFF0) | br_raw),
                        CFG_W'(($urandom & 32'h1FFFF0) | bc_raw),
                        CFG_W'(nr_raw),
                        CFG_W'(($urandom & 32'h1FE000) | nc_raw));
            ncols     = cols_eff();
            cap       = dim_eff(br_reg) * dim_eff(bc_reg);
            nblk      = (ncols + dim_eff(bc_reg) - 1) / dim_eff(bc_reg);
            phase_len = (nblk > 256) ? 24 : $urandom_range(60, 160);
            hot       = $urandom_range(0, ncols - 1);
            no_idle   = (phase == 2);
            start     = requests_sent;
            while (requests_sent - start < phase_len) begin
                roll = $urandom_range(99);
                if (roll < 5) begin
                    send_req(REQ_NONZERO, 12'($urandom), 7'($urandom));
                end else if (roll < 10) begin
                    send_req(REQ_READ_BIN, 12'($urandom),
                             $urandom_range(1) ? 7'($urandom) : 7'($urandom_range(0, cap + 1)));
                end else if (roll < 11) begin
                    send_req(REQ_CLEAR_ALL, 12'($urandom), 7'($urandom));
                end else begin
                    k = $urandom_range(0, 6);
                    for (j = 0; j < k; j++) begin
                        col = ($urandom_range(99) < 50) ? hot : $urandom_range(0, ncols - 1);
                        send_req(REQ_NONZERO, 12'(col), 7'($urandom));
                    end
                    send_req(REQ_END_ROW, 12'($urandom), 7'($urandom));
                end
            end
            for (j = 0; j <= cap + 1; j++) begin
                send_req(REQ_READ_BIN, 12'($urandom), 7'(j));
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_registers();
        test_register_clamps();
        test_counter_saturation();
        test_rows_and_clear();
        test_random_matrices();
        drain_outputs();
        repeat (20) @(posedge aclk);
        $display("requests %0d, results checked %0d, row-block flushes %0d",
                 requests_sent, outputs_checked, flushes_seen);
        $display("register loads %0d, mismatches %0d", register_loads, mismatches);
        if (mismatches == 0 && pending_outputs.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
